FILE: hw/rtl/x86alu_pkg.sv
`timescale 1ns / 1ps

package x86alu_pkg;

   localparam logic [3:0] FUNC_MOV    = 4'd0;
   localparam logic [3:0] FUNC_ADD    = 4'd1;
   localparam logic [3:0] FUNC_SUB    = 4'd2;
   localparam logic [3:0] FUNC_CMP    = 4'd3;
   localparam logic [3:0] FUNC_TEST   = 4'd4;
   localparam logic [3:0] FUNC_OR     = 4'd5;
   localparam logic [3:0] FUNC_XOR    = 4'd6;
   localparam logic [3:0] FUNC_DEC    = 4'd7;
   localparam logic [3:0] FUNC_CBW    = 4'd8;
   localparam logic [3:0] FUNC_BRANCH = 4'd9;

   localparam logic [2:0] COND_O  = 3'd0;
   localparam logic [2:0] COND_B  = 3'd1;
   localparam logic [2:0] COND_E  = 3'd2;
   localparam logic [2:0] COND_BE = 3'd3;
   localparam logic [2:0] COND_S  = 3'd4;
   localparam logic [2:0] COND_P  = 3'd5;
   localparam logic [2:0] COND_L  = 3'd6;
   localparam logic [2:0] COND_LE = 3'd7;

   typedef struct packed {
      logic [3:0]  func;
      logic        is_word;
      logic [15:0] dest_val;
      logic [15:0] src_val;
      logic [3:0]  cond;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic        write_back;
      logic        branch_taken;
      logic        flag_overflow;
      logic        flag_sign;
      logic        flag_zero;
      logic        flag_carry;
      logic        flag_parity;
   } rsp_type;

   typedef struct packed {
      logic o;
      logic s;
      logic z;
      logic c;
      logic p;
   } flags_type;

endpackage

FILE: hw/rtl/x86_16bit_alu_with_flags.sv
`timescale 1ns / 1ps

// 8086-style alu subset with a kept status flag register.
// input channel: req_valid / req_stall / req_data carry one operation item
// (func, is_word, dest_val, src_val, cond).
// result channel: rsp_valid / rsp_stall / rsp_data carry one result item per
// input item: result, write_back, branch_taken and the five flags after it.
// an item is taken into an input register, computed in one pass of
// combinational logic and captured in the result register, so rsp_valid
// rises as the item moves from the input register into the result register.
// throughput is one item per cycle while rsp_stall is low; the flag register
// is written as an item moves into the result register and feeds the next item.
// reset (synchronous) empties both registers and clears all flags.
// while rsp_stall is high and a result waits, the input register still
// takes one more item; after that req_stall follows rsp_stall until the
// result is taken. results are never dropped or repeated.
module x86_16bit_alu_with_flags (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  x86alu_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output x86alu_pkg::rsp_type  rsp_data
);

   import x86alu_pkg::*;

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      out_valid_ff;
   rsp_type   out_data_ff;
   flags_type flags_ff;
   flags_type flags_in;
   rsp_type   out_data_in;

   logic advance;
   logic take;

   logic        word;
   logic [15:0] d;
   logic [15:0] s;
   logic [15:0] r;
   logic [16:0] sum;
   logic [16:0] diff;
   logic [15:0] decv;
   logic [15:0] msb;
   logic        sgn;
   logic        ovf;
   logic        cry;
   logic        upd;
   logic        wb;
   logic        taken;
   logic        cond_t;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      word = in_data_ff.is_word;
      d    = word ? in_data_ff.dest_val : {8'h00, in_data_ff.dest_val[7:0]};
      s    = word ? in_data_ff.src_val  : {8'h00, in_data_ff.src_val[7:0]};
      msb  = word ? 16'h8000 : 16'h0080;
      sum  = {1'b0, d} + {1'b0, s};
      diff = {1'b0, d} - {1'b0, s};
      decv = d - 16'd1;

      unique case (in_data_ff.cond[3:1])
         COND_O:  cond_t = flags_ff.o;
         COND_B:  cond_t = flags_ff.c;
         COND_E:  cond_t = flags_ff.z;
         COND_BE: cond_t = flags_ff.c || flags_ff.z;
         COND_S:  cond_t = flags_ff.s;
         COND_P:  cond_t = flags_ff.p;
         COND_L:  cond_t = flags_ff.s != flags_ff.o;
         COND_LE: cond_t = flags_ff.z || (flags_ff.s != flags_ff.o);
         default: cond_t = 1'b0;
      endcase

      r     = 16'h0000;
      ovf   = 1'b0;
      cry   = 1'b0;
      upd   = 1'b0;
      wb    = 1'b0;
      taken = 1'b0;

      unique case (in_data_ff.func)
         FUNC_MOV: begin
            r  = s;
            wb = 1'b1;
         end
         FUNC_ADD: begin
            r   = word ? sum[15:0] : {8'h00, sum[7:0]};
            ovf = |(~(d ^ s) & (d ^ r) & msb);
            cry = word ? sum[16] : sum[8];
            upd = 1'b1;
            wb  = 1'b1;
         end
         FUNC_SUB, FUNC_CMP: begin
            r   = word ? diff[15:0] : {8'h00, diff[7:0]};
            ovf = |((d ^ s) & (d ^ r) & msb);
            cry = diff[16];
            upd = 1'b1;
            wb  = (in_data_ff.func == FUNC_SUB);
         end
         FUNC_TEST: begin
            r   = d & s;
            upd = 1'b1;
         end
         FUNC_OR: begin
            r   = d | s;
            upd = 1'b1;
            wb  = 1'b1;
         end
         FUNC_XOR: begin
            r   = d ^ s;
            upd = 1'b1;
            wb  = 1'b1;
         end
         FUNC_DEC: begin
            r   = word ? decv : {8'h00, decv[7:0]};
            ovf = (d == msb);
            cry = flags_ff.c;
            upd = 1'b1;
            wb  = 1'b1;
         end
         FUNC_CBW: begin
            r  = {{8{in_data_ff.dest_val[7]}}, in_data_ff.dest_val[7:0]};
            wb = 1'b1;
         end
         FUNC_BRANCH: begin
            taken = cond_t ^ in_data_ff.cond[0];
            r     = taken ? in_data_ff.src_val : 16'h0000;
         end
         default: begin
            r = 16'h0000;
         end
      endcase

      sgn = |(r & msb);

      if (upd) begin
         flags_in.o = ovf;
         flags_in.s = sgn;
         flags_in.z = (r == 16'h0000);
         flags_in.c = cry;
         flags_in.p = ~^r[7:0];
      end else begin
         flags_in = flags_ff;
      end

      out_data_in.result        = r;
      out_data_in.write_back    = wb;
      out_data_in.branch_taken  = taken;
      out_data_in.flag_overflow = flags_in.o;
      out_data_in.flag_sign     = flags_in.s;
      out_data_in.flag_zero     = flags_in.z;
      out_data_in.flag_carry    = flags_in.c;
      out_data_in.flag_parity   = flags_in.p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
